// File: design/vscf_pkg.sv
// ----------------------------------------------------------------------------
// vscf_pkg - vertical speed complementary filter package
// Sequencer states, register indices, reset values and fixed-point helpers.
// ----------------------------------------------------------------------------
package vscf_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_B0, ST_B1, ST_B2, ST_B3,
    ST_A0, ST_A1, ST_A2, ST_A3, ST_A4, ST_A5, ST_A6, ST_A7,
    ST_O0, ST_O1, ST_O2
  } vscf_state_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 31;
  localparam int unsigned ProdW    = 54;
  localparam int unsigned MulAW    = 36;
  localparam int unsigned MulBW    = 18;

  localparam logic [CfgIdxW-1:0] CFG_SHORT_ALPHA = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_LONG_ALPHA  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_BARO_DB     = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_ACC_DB      = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_BLEND_ALPHA = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_SPEED_LIMIT = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_STEP_TIME   = 3'd6;

  localparam logic [15:0] RST_SHORT_ALPHA = 16'd60293;
  localparam logic [15:0] RST_LONG_ALPHA  = 16'd60948;
  localparam logic [15:0] RST_BARO_DB     = 16'd328;
  localparam logic [15:0] RST_ACC_DB      = 16'd328;
  localparam logic [15:0] RST_BLEND_ALPHA = 16'd45875;
  localparam logic [30:0] RST_SPEED_LIMIT = 31'd1310720;
  localparam logic [15:0] RST_STEP_TIME   = 16'd1311;

  localparam logic [MulBW-1:0] CM_PER_M = 18'd100;

  typedef logic signed [ProdW-1:0] wide_t;

  function automatic logic signed [31:0] sat32(input wide_t v);
    logic signed [31:0] r;
    if (v > 54'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -54'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // zero band of +-db, threshold taken off outside it
  function automatic wide_t dead(input wide_t v, input logic [15:0] db);
    wide_t dbw;
    wide_t r;
    dbw = {38'b0, db};
    if (v > dbw) begin
      r = v - dbw;
    end else if (v < -dbw) begin
      r = v + dbw;
    end else begin
      r = '0;
    end
    return r;
  endfunction

  function automatic wide_t sx32(input logic signed [31:0] v);
    return {{(ProdW-32){v[31]}}, v};
  endfunction

endpackage

// File: design/vertical_speed_complementary_filter_unit.sv
// ----------------------------------------------------------------------------
// vertical_speed_complementary_filter_unit - baro/accel vertical speed filter
// Fuses barometer altitude and accelerometer samples into vertical speed and
// smoothed height using one shared multiplier under a small sequencer.
// ----------------------------------------------------------------------------
// Input words arrive on s_axis; tuser[0] selects the kind: 0 barometer
// sample, 1 accelerometer sample. Each word yields exactly one output word
// on m_axis carrying the fused speed (cm/s, Q16.16) and the long-term
// height (cm, Q24.8), both saturated.
// One 36x18 signed multiplier with a product register does all products.
// A barometer word steps through B0-B3 and O0-O2 before reaching the output
// register, an accelerometer word through A0-A7 and O0-O2 (three
// dot-product terms, the dt scale, the blend and two cm conversions,
// each one multiplier pass plus a write back). tready is high only while
// the sequencer is idle, so a new word is taken only once the last is done.
// The output register holds a finished word while m_axis stalls; the next
// input is accepted meanwhile and its sequence waits at the final step
// until the register frees up.
// Reset clears the filter state, restores the register defaults and
// empties the output register. cfg writes take effect at once; the user
// must make them only while the block is idle, which it does not enforce.
// ----------------------------------------------------------------------------
module vertical_speed_complementary_filter_unit
  import vscf_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // altitude_raw[31:0], acc_x[47:32], acc_y[63:48], acc_z[79:64],
  // grav_x[95:80], grav_y[111:96], grav_z[127:112]
  input  logic [127:0]        s_axis_tdata,
  // opcode[0]
  input  logic [0:0]          s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // speed_cm[31:0], height_cm[63:32]
  output logic [63:0]         m_axis_tdata,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  vscf_state_e state_q, state_d;

  logic [15:0] short_alpha_q, long_alpha_q, baro_db_q, acc_db_q;
  logic [15:0] blend_alpha_q, step_time_q;
  logic [30:0] speed_limit_q;

  logic signed [31:0] alt_raw_q;
  logic signed [15:0] accel_q [3];
  logic signed [15:0] grav_q [3];

  logic signed [31:0] alt_short_q, alt_short_d;
  logic signed [31:0] alt_long_q, alt_long_d;
  logic signed [31:0] baro_spd_q, baro_spd_d;
  logic signed [31:0] fused_spd_q, fused_spd_d;
  logic signed [31:0] spd_res_q, spd_res_d;
  logic signed [MulAW-1:0] accum_q, accum_d;

  logic                    mul_en;
  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  wide_t                   prod_q, prod_d;

  logic               m_valid_q, m_valid_d;
  logic signed [31:0] out_spd_q, out_hgt_q;
  logic               out_load;
  logic               in_acc;

  wide_t              mix_sum, inc_rnd, inc_dead, v_sum, lim, dot_first, baro_diff, d5;
  wide_t              hgt_rnd;
  logic signed [31:0] mix_base, mix_res;
  logic signed [MulAW-1:0] v_clamp;

  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign out_load      = (state_q == ST_O2) && (!m_valid_q || m_axis_tready);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {out_hgt_q, out_spd_q};

  assign prod_d = mul_a * mul_b;

  // datapath helpers
  always_comb begin
    mix_base  = (state_q == ST_A7) ? baro_spd_q : alt_raw_q;
    mix_sum   = {{6{mix_base[31]}}, mix_base, 16'b0} + prod_q + 54'sd32768;
    mix_res   = sat32(mix_sum >>> 16);
    inc_rnd   = prod_q + 54'sd33554432;
    inc_dead  = dead(inc_rnd >>> 26, acc_db_q);
    v_sum     = sx32(fused_spd_q) + inc_dead;
    lim       = {23'b0, speed_limit_q};
    if (v_sum > lim) begin
      v_clamp = lim[MulAW-1:0];
    end else if (v_sum < -lim) begin
      v_clamp = MulAW'(-lim);
    end else begin
      v_clamp = v_sum[MulAW-1:0];
    end
    dot_first = prod_q - 54'sd67108864;
    baro_diff = sx32(alt_short_q) - sx32(alt_long_q);
    d5        = (baro_diff <<< 2) + baro_diff;
    hgt_rnd   = prod_q + 54'sd128;
  end

  always_comb begin
    state_d     = state_q;
    mul_en      = 1'b0;
    mul_a       = '0;
    mul_b       = '0;
    alt_short_d = alt_short_q;
    alt_long_d  = alt_long_q;
    baro_spd_d  = baro_spd_q;
    fused_spd_d = fused_spd_q;
    spd_res_d   = spd_res_q;
    accum_d     = accum_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = s_axis_tuser[0] ? ST_A0 : ST_B0;
        end
      end
      ST_B0: begin
        mul_en  = 1'b1;
        mul_a   = MulAW'(sx32(alt_short_q) - sx32(alt_raw_q));
        mul_b   = {2'b0, short_alpha_q};
        state_d = ST_B1;
      end
      ST_B1: begin
        alt_short_d = mix_res;
        mul_en      = 1'b1;
        mul_a       = MulAW'(sx32(alt_long_q) - sx32(alt_raw_q));
        mul_b       = {2'b0, long_alpha_q};
        state_d     = ST_B2;
      end
      ST_B2: begin
        alt_long_d = mix_res;
        state_d    = ST_B3;
      end
      ST_B3: begin
        baro_spd_d = sat32(dead(d5, baro_db_q));
        state_d    = ST_O0;
      end
      ST_A0: begin
        mul_en  = 1'b1;
        mul_a   = MulAW'(accel_q[0]);
        mul_b   = MulBW'(grav_q[0]);
        state_d = ST_A1;
      end
      ST_A1: begin
        accum_d = dot_first[MulAW-1:0];
        mul_en  = 1'b1;
        mul_a   = MulAW'(accel_q[1]);
        mul_b   = MulBW'(grav_q[1]);
        state_d = ST_A2;
      end
      ST_A2: begin
        accum_d = accum_q + prod_q[MulAW-1:0];
        mul_en  = 1'b1;
        mul_a   = MulAW'(accel_q[2]);
        mul_b   = MulBW'(grav_q[2]);
        state_d = ST_A3;
      end
      ST_A3: begin
        accum_d = accum_q + prod_q[MulAW-1:0];
        state_d = ST_A4;
      end
      ST_A4: begin
        mul_en  = 1'b1;
        mul_a   = accum_q;
        mul_b   = {2'b0, step_time_q};
        state_d = ST_A5;
      end
      ST_A5: begin
        accum_d = v_clamp;
        state_d = ST_A6;
      end
      ST_A6: begin
        mul_en  = 1'b1;
        mul_a   = accum_q - MulAW'(baro_spd_q);
        mul_b   = {2'b0, blend_alpha_q};
        state_d = ST_A7;
      end
      ST_A7: begin
        fused_spd_d = mix_res;
        state_d     = ST_O0;
      end
      ST_O0: begin
        mul_en  = 1'b1;
        mul_a   = (state_q == ST_O0) ? MulAW'(fused_spd_q) : '0;
        mul_b   = CM_PER_M;
        state_d = ST_O1;
      end
      ST_O1: begin
        spd_res_d = sat32(prod_q);
        mul_en    = 1'b1;
        mul_a     = MulAW'(alt_long_q);
        mul_b     = CM_PER_M;
        state_d   = ST_O2;
      end
      ST_O2: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end else begin
      m_valid_d = m_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      m_valid_q     <= 1'b0;
      alt_short_q   <= '0;
      alt_long_q    <= '0;
      baro_spd_q    <= '0;
      fused_spd_q   <= '0;
      short_alpha_q <= RST_SHORT_ALPHA;
      long_alpha_q  <= RST_LONG_ALPHA;
      baro_db_q     <= RST_BARO_DB;
      acc_db_q      <= RST_ACC_DB;
      blend_alpha_q <= RST_BLEND_ALPHA;
      speed_limit_q <= RST_SPEED_LIMIT;
      step_time_q   <= RST_STEP_TIME;
    end else begin
      state_q     <= state_d;
      m_valid_q   <= m_valid_d;
      alt_short_q <= alt_short_d;
      alt_long_q  <= alt_long_d;
      baro_spd_q  <= baro_spd_d;
      fused_spd_q <= fused_spd_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SHORT_ALPHA: short_alpha_q <= cfg_data_i[15:0];
          CFG_LONG_ALPHA:  long_alpha_q  <= cfg_data_i[15:0];
          CFG_BARO_DB:     baro_db_q     <= cfg_data_i[15:0];
          CFG_ACC_DB:      acc_db_q      <= cfg_data_i[15:0];
          CFG_BLEND_ALPHA: blend_alpha_q <= cfg_data_i[15:0];
          CFG_SPEED_LIMIT: speed_limit_q <= cfg_data_i;
          CFG_STEP_TIME:   step_time_q   <= cfg_data_i[15:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      alt_raw_q  <= s_axis_tdata[31:0];
      accel_q[0] <= s_axis_tdata[47:32];
      accel_q[1] <= s_axis_tdata[63:48];
      accel_q[2] <= s_axis_tdata[79:64];
      grav_q[0]  <= s_axis_tdata[95:80];
      grav_q[1]  <= s_axis_tdata[111:96];
      grav_q[2]  <= s_axis_tdata[127:112];
    end
    if (mul_en) begin
      prod_q <= prod_d;
    end
    accum_q   <= accum_d;
    spd_res_q <= spd_res_d;
    if (out_load) begin
      out_spd_q <= spd_res_q;
      out_hgt_q <= sat32(hgt_rnd >>> 8);
    end
  end

  // assertions
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready)
    else $error("input accepted while a word is in flight");

  a_valid_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q == ST_O2))
    else $error("output valid raised outside the final step");

  a_speed_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_A6) |->
      (sx32(accum_q[31:0]) <= lim && sx32(accum_q[31:0]) >= -lim))
    else $error("integrated speed outside the limit");

  a_prod_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_O2 && !out_load) |=> $stable(prod_q))
    else $error("height product lost during output stall");

endmodule

// File: tb/vertical_speed_complementary_filter_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vertical_speed_complementary_filter_unit_tb - self-checking testbench
// Feeds barometer and accelerometer words through the filter with random
// stalls on both streams. A behavioral fixed-point model tracks the expected
// speed and height; output words are checked against it, typed rows against
// their own values. A directed table runs first, then random register sets.
// ----------------------------------------------------------------------------
module vertical_speed_complementary_filter_unit_tb;
  import vscf_pkg::*;

  localparam logic   OP_BARO     = 1'b0;
  localparam logic   OP_ACCEL    = 1'b1;
  localparam int     PHASE_WORDS = 180;
  localparam int     DRAIN_PAD   = 16;
  localparam int     RX_HOLD     = 300;
  localparam int     N_DIR       = 22;
  localparam int     TIMEOUT_NS  = 2_000_000;
  localparam longint S32_MAX     = 64'sd2147483647;
  localparam longint S32_MIN     = -64'sd2147483648;
  localparam longint ONE_G       = 64'sd1 <<< 26;

  typedef struct packed {
    logic               op;
    logic signed [31:0] alt;
    logic signed [15:0] ax, ay, az;
    logic signed [15:0] gx, gy, gz;
  } sample_t;

  typedef struct packed {
    logic signed [31:0] height_cm;
    logic signed [31:0] speed_cm;
  } out_word_t;

  typedef struct packed {
    logic [15:0] short_a;
    logic [15:0] long_a;
    logic [15:0] baro_db;
    logic [15:0] acc_db;
    logic [15:0] blend_a;
    logic [30:0] lim;
    logic [15:0] step;
  } regset_t;

  typedef struct packed {
    sample_t            s;
    logic               typed;
    logic signed [31:0] want_speed;
    logic signed [31:0] want_height;
  } dir_row_t;

  localparam regset_t RST_REGS = '{RST_SHORT_ALPHA, RST_LONG_ALPHA, RST_BARO_DB,
                                   RST_ACC_DB, RST_BLEND_ALPHA, RST_SPEED_LIMIT,
                                   RST_STEP_TIME};

  // op, alt, ax, ay, az, gx, gy, gz | typed, speed_cm, height_cm
  localparam dir_row_t DIR_TAB [N_DIR] = '{
    '{'{OP_BARO,  32'sh00000000, 16'sh0000, 16'sh0000, 16'sh0000,
        16'sh0000, 16'sh0000, 16'sh0000}, 1'b1, 32'sd0, 32'sd0},
    '{'{OP_ACCEL, 32'sh00000000, 16'sh0000, 16'sh0000, 16'sh0000,
        16'sh0000, 16'sh0000, 16'sh0000}, 1'b0, 32'sd0, 32'sd0},
    // exactly 1 g along gravity
    '{'{OP_ACCEL, 32'sh00000000, 16'sh0000, 16'sh0000, 16'sd4096,
        16'sh0000, 16'sh0000, 16'sd16384}, 1'b0, 32'sd0, 32'sd0},
    // increment at +db, just above, at -db, just below
    '{'{OP_ACCEL, 32'sh00000000, 16'sh0000, 16'sh0000, 16'sd5120,
        16'sh0000, 16'sh0000, 16'sd16384}, 1'b0, 32'sd0, 32'sd0},
    '{'{OP_ACCEL, 32'sh00000000, 16'sh0000, 16'sh0000, 16'sd5124,
        16'sh0000, 16'sh0000, 16'sd16384}, 1'b0, 32'sd0, 32'sd0},
    '{'{OP_ACCEL, 32'sh00000000, 16'sh0000, 16'sh0000, 16'sd3072,
        16'sh0000, 16'sh0000, 16'sd16384}, 1'b0, 32'sd0, 32'sd0},
    '{'{OP_ACCEL, 32'sh00000000, 16'sh0000, 16'sh0000, 16'sd3068,
        16'sh0000, 16'sh0000, 16'sd16384}, 1'b0, 32'sd0, 32'sd0},
    '{'{OP_BARO,  32'sh7fffffff, 16'sh0000, 16'sh0000, 16'sh0000,
        16'sh0000, 16'sh0000, 16'sh0000}, 1'b0, 32'sd0, 32'sd0},
    '{'{OP_BARO,  32'sh7fffffff, 16'sh0000, 16'sh0000, 16'sh0000,
        16'sh0000, 16'sh0000, 16'sh0000}, 1'b0, 32'sd0, 32'sd0},
    '{'{OP_BARO,  32'sh80000000, 16'sh0000, 16'sh0000, 16'sh0000,
        16'sh0000, 16'sh0000, 16'sh0000}, 1'b0, 32'sd0, 32'sd0},
    '{'{OP_BARO,  32'sh80000000, 16'sh0000, 16'sh0000, 16'sh0000,
        16'sh0000, 16'sh0000, 16'sh0000}, 1'b0, 32'sd0, 32'sd0},
    '{'{OP_ACCEL, 32'sh00000000, 16'sh7fff, 16'sh7fff, 16'sh7fff,
        16'sh7fff, 16'sh7fff, 16'sh7fff}, 1'b0, 32'sd0, 32'sd0},
    '{'{OP_ACCEL, 32'sh00000000, 16'sh8000, 16'sh8000, 16'sh8000,
        16'sh7fff, 16'sh7fff, 16'sh7fff}, 1'b0, 32'sd0, 32'sd0},
    '{'{OP_ACCEL, 32'sh00000000, 16'sh8000, 16'sh8000, 16'sh8000,
        16'sh8000, 16'sh8000, 16'sh8000}, 1'b0, 32'sd0, 32'sd0},
    '{'{OP_ACCEL, 32'sh00000000, 16'sh7fff, 16'sh8000, 16'sh7fff,
        16'sh8000, 16'sh7fff, 16'sh8000}, 1'b0, 32'sd0, 32'sd0},
    // fields the kind does not use are loaded
    '{'{OP_BARO,  32'sh00640000, 16'sh7fff, 16'sh8000, 16'shffff,
        16'sh7fff, 16'sh8000, 16'shffff}, 1'b0, 32'sd0, 32'sd0},
    '{'{OP_ACCEL, 32'sh80000000, 16'sd100,  16'sh0000, 16'sd4096,
        16'sd200,  16'sh0000, 16'sd16384}, 1'b0, 32'sd0, 32'sd0},
    '{'{OP_BARO,  32'sh55555555, 16'sh0000, 16'sh0000, 16'sh0000,
        16'sh0000, 16'sh0000, 16'sh0000}, 1'b0, 32'sd0, 32'sd0},
    '{'{OP_BARO,  32'shaaaaaaaa, 16'sh0000, 16'sh0000, 16'sh0000,
        16'sh0000, 16'sh0000, 16'sh0000}, 1'b0, 32'sd0, 32'sd0},
    '{'{OP_ACCEL, 32'sh00000000, 16'sh5555, 16'shaaaa, 16'sh5555,
        16'shaaaa, 16'sh5555, 16'shaaaa}, 1'b0, 32'sd0, 32'sd0},
    '{'{OP_ACCEL, 32'sh00000000, 16'shaaaa, 16'sh5555, 16'shaaaa,
        16'sh5555, 16'shaaaa, 16'sh5555}, 1'b0, 32'sd0, 32'sd0},
    '{'{OP_BARO,  32'sh00000000, 16'sh0000, 16'sh0000, 16'sh0000,
        16'sh0000, 16'sh0000, 16'sh0000}, 1'b0, 32'sd0, 32'sd0}
  };

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [127:0]        s_axis_tdata  = '0;
  logic [0:0]          s_axis_tuser  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [63:0]         m_axis_tdata;
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i     = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;

  vertical_speed_complementary_filter_unit u_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i
  );

  always #1 clk_i = ~clk_i;

  // filter model state
  regset_t            regs_m;
  logic signed [31:0] short_avg = '0;
  logic signed [31:0] long_avg  = '0;
  logic signed [31:0] baro_vel  = '0;
  logic signed [31:0] fused_vel = '0;
  logic signed [31:0] out_vel   = '0;
  logic signed [31:0] alt_track = 32'sh00640000;

  out_word_t speed_height_q[$];
  out_word_t got_w, want_w;

  int  n_err      = 0;
  int  n_checked  = 0;
  int  n_baro     = 0;
  int  n_accel    = 0;
  int  n_sets     = 1;
  int  n_holds    = 0;
  int  n_hold_req = 0;
  int  tx_gap_pct = 20;
  bit  quiet_run  = 1'b0;

  function automatic logic signed [31:0] sat_s32(input longint v);
    if (v > S32_MAX) return 32'sh7fffffff;
    if (v < S32_MIN) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic longint shr_round(input longint v, input int sh);
    return (v + (64'sd1 <<< (sh - 1))) >>> sh;
  endfunction

  function automatic longint dead_zone(input longint v, input logic [15:0] db);
    longint d;
    d = db;
    if (v > d) return v - d;
    if (v < -d) return v + d;
    return 0;
  endfunction

  function automatic logic signed [31:0] weigh(input logic signed [31:0] prev,
                                               input logic signed [31:0] nxt,
                                               input logic [15:0] w);
    longint wl;
    wl = w;
    return sat_s32(shr_round(longint'(prev) * wl + longint'(nxt) * (64'sd65536 - wl), 16));
  endfunction

  function automatic out_word_t fuse_sample(input sample_t s);
    longint    diff, dot, inc, vel, lim, dt;
    out_word_t o;
    if (s.op == OP_BARO) begin
      short_avg = weigh(short_avg, s.alt, regs_m.short_a);
      long_avg  = weigh(long_avg, s.alt, regs_m.long_a);
      diff = 5 * (longint'(short_avg) - longint'(long_avg));
      baro_vel = sat_s32(dead_zone(diff, regs_m.baro_db));
    end else begin
      dot = longint'(s.ax) * longint'(s.gx) + longint'(s.ay) * longint'(s.gy)
          + longint'(s.az) * longint'(s.gz) - ONE_G;
      dt  = regs_m.step;
      inc = dead_zone(shr_round(dot * dt, 26), regs_m.acc_db);
      vel = longint'(fused_vel) + inc;
      lim = regs_m.lim;
      if (vel > lim) vel = lim;
      if (vel < -lim) vel = -lim;
      fused_vel = weigh(vel[31:0], baro_vel, regs_m.blend_a);
      out_vel = fused_vel;
    end
    o.speed_cm  = sat_s32(longint'(out_vel) * 100);
    o.height_cm = sat_s32(shr_round(longint'(long_avg) * 100, 8));
    return o;
  endfunction

  function automatic int jitter(input int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic sample_t rand_sample();
    sample_t s;
    s.op  = 1'($urandom_range(0, 1));
    s.alt = $urandom;
    s.ax  = 16'($urandom);
    s.ay  = 16'($urandom);
    s.az  = 16'($urandom);
    s.gx  = 16'($urandom);
    s.gy  = 16'($urandom);
    s.gz  = 16'($urandom);
    // mostly plausible flight data, the rest full-range noise
    if ($urandom_range(0, 3) != 0) begin
      alt_track = alt_track + jitter(4096);
      if (s.op == OP_BARO) begin
        s.alt = alt_track + jitter(30000);
      end else begin
        s.ax = 16'(jitter(400));
        s.ay = 16'(jitter(400));
        s.az = 16'(4096 + jitter(600));
        s.gx = 16'(jitter(2000));
        s.gy = 16'(jitter(2000));
        s.gz = 16'(16384 - int'($urandom_range(0, 1500)));
      end
    end
    return s;
  endfunction

  function automatic logic [15:0] pick_coef();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic regset_t rand_regs();
    regset_t r;
    r.short_a = pick_coef();
    r.long_a  = pick_coef();
    r.baro_db = pick_coef();
    r.acc_db  = pick_coef();
    r.blend_a = pick_coef();
    r.step    = pick_coef();
    case ($urandom_range(0, 3))
      0: r.lim = 31'h7fffffff;
      1: r.lim = 31'($urandom_range(0, 32'h00200000));
      default: r.lim = 31'($urandom);
    endcase
    return r;
  endfunction

  task automatic send_sample(input sample_t s, input logic typed, input out_word_t want);
    int        gap;
    out_word_t pred;
    if (!quiet_run && ($urandom_range(0, 99) < tx_gap_pct)) begin
      s_axis_tvalid <= 1'b0;
      gap = $urandom_range(1, 11);
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= s.op;
    s_axis_tdata  <= {s.gz, s.gy, s.gx, s.az, s.ay, s.ax, s.alt};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pred = fuse_sample(s);
    speed_height_q.push_back(typed ? want : pred);
    if (s.op == OP_BARO) n_baro++;
    else n_accel++;
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (speed_height_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_PAD) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
  endtask

  task automatic apply_regs(input regset_t r);
    cfg_write(CFG_SHORT_ALPHA, {15'd0, r.short_a});
    cfg_write(CFG_LONG_ALPHA,  {15'd0, r.long_a});
    cfg_write(CFG_BARO_DB,     {15'd0, r.baro_db});
    cfg_write(CFG_ACC_DB,      {15'd0, r.acc_db});
    cfg_write(CFG_BLEND_ALPHA, {15'd0, r.blend_a});
    cfg_write(CFG_SPEED_LIMIT, r.lim);
    cfg_write(CFG_STEP_TIME,   {15'd0, r.step});
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    regs_m = r;
    n_sets++;
  endtask

  task automatic run_phase(input regset_t r, input bit hold_rx, input bit pause_mid);
    int i;
    apply_regs(r);
    for (i = 0; i < PHASE_WORDS; i++) begin
      if (i % 50 == 0) begin
        case ($urandom_range(0, 2))
          0: tx_gap_pct = 0;
          1: tx_gap_pct = 10;
          default: tx_gap_pct = 40;
        endcase
      end
      if (hold_rx && i == 40) n_hold_req++;
      if (pause_mid && i == PHASE_WORDS / 2) drain_results();
      send_sample(rand_sample(), 1'b0, '0);
    end
    drain_results();
  endtask

  initial begin : rx_side
    int n;
    @(posedge clk_i);
    forever begin
      if (n_holds < n_hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (RX_HOLD) @(posedge clk_i);
        n_holds++;
      end else if (!quiet_run && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        n = $urandom_range(1, 11);
        repeat (n) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        n = $urandom_range(1, 40);
        repeat (n) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin : out_check
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_w = m_axis_tdata;
      n_checked++;
      if (speed_height_q.size() == 0) begin
        n_err++;
        if (n_err <= 10)
          $display("unexpected word: speed_cm %0d height_cm %0d",
                   got_w.speed_cm, got_w.height_cm);
      end else begin
        want_w = speed_height_q.pop_front();
        if (got_w.speed_cm !== want_w.speed_cm || got_w.height_cm !== want_w.height_cm) begin
          n_err++;
          if (n_err <= 10)
            $display("mismatch word %0d: speed_cm exp %0d got %0d, height_cm exp %0d got %0d",
                     n_checked, want_w.speed_cm, got_w.speed_cm,
                     want_w.height_cm, got_w.height_cm);
        end
      end
    end
  end

  initial begin : stim
    int i;
    regs_m = RST_REGS;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (i = 0; i < N_DIR; i++)
      send_sample(DIR_TAB[i].s, DIR_TAB[i].typed,
                  {DIR_TAB[i].want_height, DIR_TAB[i].want_speed});
    drain_results();
    run_phase('0, 1'b0, 1'b0);
    run_phase('1, 1'b0, 1'b0);
    run_phase(RST_REGS, 1'b0, 1'b0);
    for (i = 0; i < 5; i++) begin
      quiet_run = (i == 4);
      run_phase(rand_regs(), i == 0, i == 1);
    end
    $display("Run: %0d baro and %0d accel words over %0d register sets, %0d words checked",
             n_baro, n_accel, n_sets, n_checked);
    $display("Long output hold-offs: %0d, errors: %0d", n_holds, n_err);
    if (n_err == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("TB_ERROR");
    $finish;
  end

endmodule
